[sv/mbvd_pkg.sv]
package mbvd_pkg;

    localparam int MAX_ROW_LEN = 512;
    localparam int MAX_ROWS    = 512;

    localparam int LABEL_W   = 8;
    localparam int POS_W     = 9;
    localparam int SLICE_W   = 10;
    localparam int LEN_REG_W = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam int COL_W = $clog2(MAX_ROW_LEN);
    localparam int LEN_W = $clog2(MAX_ROW_LEN + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int WORD_W = 2 * LABEL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELECTED_LABEL = 2'd0,
        REG_ROW_LENGTH     = 2'd1,
        REG_ROW_COUNT      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   rd_addr;
        logic [SLICE_W-1:0] slice;
        logic               has_result;
        logic               first_col;
        logic               last_col;
        logic               top_rows;
        logic               below_out;
        logic               last_of_slice;
        logic               len_one;
        logic               len_two;
    } pos_t;

    typedef struct packed {
        logic [LABEL_W-1:0] mid;
        logic [LABEL_W-1:0] up;
        logic [LABEL_W-1:0] left;
        logic [LABEL_W-1:0] right;
    } nbr_t;

endpackage

[sv/mask_boundary_voxel_detect.sv]
// channel | dir | handshake             | payload
// s_      | in  | s_valid / s_ready     | s_voxel_label
// m_      | out | m_valid / m_ready     | m_pos_row m_pos_col m_slice_number m_is_edge
//         |     |                       | m_last_of_slice
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index cfg_data
//
// one voxel per cycle while s_ready is high; a result appears in the cycle after its transfer
// rate set by the line memory: one read and one write of a 16-bit column word per voxel
// s_ready drops only while a result waits in the output register and m_ready is low
// reset clears counters and m_valid, loads config defaults; line memory is not cleared
module mask_boundary_voxel_detect (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mbvd_pkg::LABEL_W-1:0]   s_voxel_label,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mbvd_pkg::POS_W-1:0]     m_pos_row,
    output logic [mbvd_pkg::POS_W-1:0]     m_pos_col,
    output logic [mbvd_pkg::SLICE_W-1:0]   m_slice_number,
    output logic                           m_is_edge,
    output logic                           m_last_of_slice,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbvd_pkg::CFG_W-1:0]     cfg_data
);
    import mbvd_pkg::*;

    logic [LABEL_W-1:0]   sel_reg;
    logic [LEN_REG_W-1:0] row_length_reg;
    logic [LEN_REG_W-1:0] row_count_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [POS_W-1:0]     pos_row_reg;
    logic [POS_W-1:0]     pos_col_reg;
    logic [SLICE_W-1:0]   slice_reg;
    logic                 is_edge_reg;
    logic                 last_reg;

    logic   acc;
    logic   edge_c;
    pos_t   pos;
    nbr_t   nbr;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign acc       = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg        <= '0;
            row_length_reg <= LEN_REG_W'(MAX_ROW_LEN);
            row_count_reg  <= LEN_REG_W'(MAX_ROWS);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SELECTED_LABEL: sel_reg <= cfg_data[LABEL_W-1:0];
                REG_ROW_LENGTH:     row_length_reg <= cfg_data[LEN_REG_W-1:0];
                REG_ROW_COUNT:      row_count_reg <= cfg_data[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    mbvd_raster u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (acc),
        .row_length(row_length_reg),
        .row_count (row_count_reg),
        .pos       (pos)
    );

    mbvd_window u_window (
        .aclk       (aclk),
        .accept     (acc),
        .voxel_label(s_voxel_label),
        .pos        (pos),
        .nbr        (nbr)
    );

    // neighbours outside the slice count as differing
    assign edge_c = (sel_reg != '0) && (nbr.mid == sel_reg) &&
                    (pos.first_col || nbr.left != sel_reg ||
                     pos.last_col || nbr.right != sel_reg ||
                     pos.top_rows || nbr.up != sel_reg ||
                     pos.below_out || s_voxel_label != sel_reg);

    always_comb begin
        if (acc && pos.has_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && pos.has_result) begin
            pos_row_reg <= POS_W'(pos.row - ROW_W'(1));
            pos_col_reg <= POS_W'(pos.col);
            slice_reg   <= pos.slice;
            is_edge_reg <= edge_c;
            last_reg    <= pos.last_of_slice;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_row       = pos_row_reg;
    assign m_pos_col       = pos_col_reg;
    assign m_slice_number  = slice_reg;
    assign m_is_edge       = is_edge_reg;
    assign m_last_of_slice = last_reg;

    a_rise_from_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(acc && pos.has_result))
        else $error("result appeared without an input transfer");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && pos.has_result |=> m_valid)
        else $error("result of a transfer was dropped");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(acc && pos.has_result) |=> !m_valid)
        else $error("result repeated after its transfer");

    a_no_first_row_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && !pos.has_result && (!m_valid || m_ready) |=> !m_valid)
        else $error("first row produced a result");

endmodule

[sv/mbvd_ram.sv]
module mbvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/mbvd_raster.sv]
module mbvd_raster (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [mbvd_pkg::LEN_REG_W-1:0] row_length,
    input  logic [mbvd_pkg::LEN_REG_W-1:0] row_count,
    output mbvd_pkg::pos_t                 pos
);
    import mbvd_pkg::*;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;

    logic [LEN_W-1:0] len_eff;
    logic [ROW_W-1:0] rows_eff;
    logic [COL_W-1:0] c_eff;
    logic [ROW_W-1:0] r_eff;
    logic [LEN_W:0]   addr_sum;
    logic [LEN_W:0]   addr_wrap;
    logic             last_col;

    always_comb begin
        if (row_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(row_length) > MAX_ROW_LEN) begin
            len_eff = LEN_W'(MAX_ROW_LEN);
        end else begin
            len_eff = LEN_W'(row_length);
        end
        if (row_count == '0) begin
            rows_eff = ROW_W'(1);
        end else if (int'(row_count) > MAX_ROWS) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = ROW_W'(row_count);
        end
    end

    // counters left beyond a shrunk length are pinned to the last column / padding row
    always_comb begin
        if (LEN_W'(col_reg) >= len_eff) begin
            c_eff = COL_W'(len_eff - LEN_W'(1));
        end else begin
            c_eff = col_reg;
        end
        if (row_reg > rows_eff) begin
            r_eff = rows_eff;
        end else begin
            r_eff = row_reg;
        end
    end

    assign last_col  = (LEN_W'(c_eff) == len_eff - LEN_W'(1));
    assign addr_sum  = (LEN_W + 1)'(c_eff) + (LEN_W + 1)'(2);
    assign addr_wrap = (addr_sum >= (LEN_W + 1)'(len_eff)) ?
                       addr_sum - (LEN_W + 1)'(len_eff) : addr_sum;

    always_comb begin
        col_next   = c_eff;
        row_next   = r_eff;
        slice_next = slice_reg;
        if (!last_col) begin
            col_next = c_eff + COL_W'(1);
        end else begin
            col_next = '0;
            if (r_eff < rows_eff) begin
                row_next = r_eff + ROW_W'(1);
            end else begin
                row_next   = '0;
                slice_next = slice_reg + SLICE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            slice_reg <= '0;
        end else if (accept) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            slice_reg <= slice_next;
        end
    end

    always_comb begin
        pos.row           = r_eff;
        pos.col           = c_eff;
        pos.rd_addr       = COL_W'(addr_wrap);
        pos.slice         = slice_reg;
        pos.has_result    = (r_eff != '0);
        pos.first_col     = (c_eff == '0);
        pos.last_col      = last_col;
        pos.top_rows      = (r_eff < ROW_W'(2));
        pos.below_out     = (r_eff >= rows_eff);
        pos.last_of_slice = (r_eff >= rows_eff) && last_col;
        pos.len_one       = (len_eff == LEN_W'(1));
        pos.len_two       = (len_eff == LEN_W'(2));
    end

    a_slice_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pos.last_of_slice |=> slice_reg == $past(slice_reg) + SLICE_W'(1))
        else $error("slice count did not advance after last voxel");

    a_slice_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !pos.last_of_slice |=> slice_reg == $past(slice_reg))
        else $error("slice count moved inside a slice");

endmodule

[sv/mbvd_window.sv]
module mbvd_window (
    input  logic                         aclk,
    input  logic                         accept,
    input  logic [mbvd_pkg::LABEL_W-1:0] voxel_label,
    input  mbvd_pkg::pos_t               pos,
    output mbvd_pkg::nbr_t               nbr
);
    import mbvd_pkg::*;

    // word per column: upper byte two rows back, lower byte one row back
    logic [WORD_W-1:0]  ram_q;
    logic [WORD_W-1:0]  cur_word_reg;
    logic [WORD_W-1:0]  w1_reg;
    logic [WORD_W-1:0]  w2_reg;
    logic [LABEL_W-1:0] prev_mid_reg;
    logic [WORD_W-1:0]  word_c;
    logic [WORD_W-1:0]  wr_word;

    mbvd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_ROW_LEN)
    ) u_line_ram (
        .aclk (aclk),
        .we   (accept),
        .waddr(pos.col),
        .wdata(wr_word),
        .re   (accept),
        .raddr(pos.rd_addr),
        .rdata(ram_q)
    );

    // rows of one or two voxels come from the last written words
    always_comb begin
        if (pos.len_one) begin
            word_c = w1_reg;
        end else if (pos.len_two) begin
            word_c = w2_reg;
        end else begin
            word_c = cur_word_reg;
        end
    end

    assign wr_word = {word_c[LABEL_W-1:0], voxel_label};

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_word_reg <= ram_q;
            w1_reg       <= wr_word;
            w2_reg       <= w1_reg;
            prev_mid_reg <= word_c[LABEL_W-1:0];
        end
    end

    always_comb begin
        nbr.mid   = word_c[LABEL_W-1:0];
        nbr.up    = word_c[WORD_W-1:LABEL_W];
        nbr.left  = prev_mid_reg;
        nbr.right = pos.len_two ? w1_reg[LABEL_W-1:0] : ram_q[LABEL_W-1:0];
    end

endmodule
